@@ sv/mrcs_pkg.sv @@
`timescale 1ns / 1ps

package mrcs_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int COIL_COUNT  = 256;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int COIL_AW     = $clog2(COIL_COUNT);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    localparam logic [7:0] FC_READ       = 8'h01;
    localparam logic [7:0] FC_WRITE_ONE  = 8'h05;
    localparam logic [7:0] FC_WRITE_MANY = 8'h0F;

    localparam logic [7:0] ERR_DATA  = 8'h03;
    localparam logic [7:0] ERR_OTHER = 8'h04;

    localparam logic [15:0] READ_COUNT_CAP = 16'd256;

    localparam logic [1:0] CFG_ADDR_MIN = 2'd0;
    localparam logic [1:0] CFG_ADDR_MAX = 2'd1;
    localparam logic [1:0] CFG_LEN_MAX  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CK_RD,
        ST_CK_XOR,
        ST_CK_BIT,
        ST_CHECK,
        ST_WM_RD,
        ST_WM_CAP,
        ST_WM_BIT,
        ST_RC_RD,
        ST_RC_CAP,
        ST_EMIT,
        ST_EM_BIT
    } state_t;

    typedef enum logic [1:0] {
        RK_EXC,
        RK_ECHO,
        RK_READ
    } resp_kind_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc);
        logic [15:0] shifted;
        shifted = {1'b0, crc[15:1]};
        crc_step = crc[0] ? (shifted ^ CRC_POLY) : shifted;
    endfunction

endpackage

@@ sv/modbus_rtu_coil_server_unit.sv @@
`timescale 1ns / 1ps

// Modbus RTU coil server for function codes 1, 5 and 15. An item is one received
// frame byte; a byte without frame_end is taken while idle and busy stays low.
// On the frame_end byte of an n-byte frame, n from 4 to 64, the block goes busy:
// one shared bit-serial CRC unit checks the n-2 bytes ahead of the CRC, each
// read, XORed in and shifted bit by bit; coils are written one per cycle, pausing
// to fetch each data byte, or read bit by bit through a read and a capture state.
// Each response byte other than the CRC is strobed on tx_valid for one cycle and
// then folded into the CRC bit by bit; the CRC bytes are strobed alone. The
// receiver cannot stall the block, so every strobed byte must be taken on that
// cycle.
module modbus_rtu_coil_server_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       tx_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);
    import mrcs_pkg::*;

    state_t      state_reg, state_next;
    resp_kind_t  kind_reg, kind_next;
    logic [6:0]  count_reg, count_next;
    logic [6:0]  n_reg, n_next;
    logic [7:0]  hdr_reg [6];
    logic [7:0]  prev1_reg, prev2_reg;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  bit_reg, bit_next;
    logic [5:0]  idx_reg, idx_next;
    logic [8:0]  i_reg, i_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  nb_reg, nb_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_last_reg, tx_last_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  addr_min_reg, addr_max_reg;
    logic [8:0]  len_max_reg;

    logic [7:0]  frame_mem [FRAME_BYTES];
    logic [7:0]  frame_rd_reg;
    logic [FRAME_AW-1:0] frame_raddr;
    logic        coil_mem [COIL_COUNT];
    logic [COIL_COUNT-1:0] coil_vld_reg;
    logic        coil_rd_reg;
    logic        coil_we;
    logic [COIL_AW-1:0] coil_waddr, coil_raddr;
    logic        coil_wdata;

    logic        accept;
    logic [15:0] addr, qty;
    logic [16:0] addr_sum;
    logic [16:0] read_end;
    logic [14:0] wm_need;
    logic [9:0]  rd_nb;
    logic [5:0]  last_pos;
    logic [7:0]  src_byte;
    logic        crc_byte;
    logic        crc_ok;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign tx_valid  = tx_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_last   = tx_last_reg;

    assign addr     = {hdr_reg[2], hdr_reg[3]};
    assign qty      = {hdr_reg[4], hdr_reg[5]};
    assign addr_sum = {1'b0, addr} + {8'd0, i_reg};
    assign read_end = {1'b0, addr} + {1'b0, qty};
    assign wm_need  = 15'd9 + {2'b0, qty[15:3]} + {14'd0, |qty[2:0]};
    assign rd_nb    = qty[9:0] + 10'd7;
    assign crc_ok   = (crc_reg == {prev1_reg, prev2_reg});
    assign coil_raddr = addr_sum[COIL_AW-1:0];

    always_comb
    begin
        case (kind_reg)
            RK_EXC:  last_pos = 6'd2;
            RK_ECHO: last_pos = 6'd7;
            default: last_pos = nb_reg + 6'd4;
        endcase
    end

    always_comb
    begin
        src_byte = data_reg;
        crc_byte = 1'b0;
        case (kind_reg)
            RK_EXC:
            begin
                if (pos_reg == 6'd0)
                    src_byte = hdr_reg[0];
                else if (pos_reg == 6'd1)
                    src_byte = hdr_reg[1] | EXC_FLAG;
                else
                    src_byte = code_reg;
            end
            RK_ECHO:
            begin
                if (pos_reg < 6'd6)
                    src_byte = hdr_reg[pos_reg[2:0]];
                else if (pos_reg == 6'd6)
                begin
                    src_byte = crc_reg[7:0];
                    crc_byte = 1'b1;
                end
                else
                begin
                    src_byte = crc_reg[15:8];
                    crc_byte = 1'b1;
                end
            end
            default:
            begin
                if (pos_reg == 6'd0)
                    src_byte = hdr_reg[0];
                else if (pos_reg == 6'd1)
                    src_byte = FC_READ;
                else if (pos_reg == 6'd2)
                    src_byte = {2'b0, nb_reg};
                else if (pos_reg == last_pos - 6'd1)
                begin
                    src_byte = crc_reg[7:0];
                    crc_byte = 1'b1;
                end
                else if (pos_reg == last_pos)
                begin
                    src_byte = crc_reg[15:8];
                    crc_byte = 1'b1;
                end
                else
                    src_byte = data_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && frame_end)
                begin
                    if (count_reg < 7'd3 || count_reg >= 7'(FRAME_BYTES))
                        state_next = ST_IDLE;
                    else
                        state_next = ST_CK_RD;
                end
            end
            ST_CK_RD:  state_next = ST_CK_XOR;
            ST_CK_XOR: state_next = ST_CK_BIT;
            ST_CK_BIT:
            begin
                if (bit_reg == 3'd7)
                    state_next = ({1'b0, idx_reg} == n_reg - 7'd3) ? ST_CHECK : ST_CK_RD;
            end
            ST_CHECK:
            begin
                state_next = ST_IDLE;
                if (crc_ok)
                begin
                    case (hdr_reg[1])
                        FC_READ:
                        begin
                            if (n_reg != 7'd8)
                                state_next = ST_EMIT;
                            else if (addr < {8'd0, addr_min_reg} || addr > {8'd0, addr_max_reg})
                                state_next = ST_IDLE;
                            else if (qty > {7'd0, len_max_reg} || qty > READ_COUNT_CAP)
                                state_next = ST_EMIT;
                            else if (read_end > 17'(COIL_COUNT))
                                state_next = ST_IDLE;
                            else
                                state_next = ST_EMIT;
                        end
                        FC_WRITE_ONE:
                        begin
                            if (n_reg != 7'd8)
                                state_next = ST_EMIT;
                            else if (addr >= 16'(COIL_COUNT))
                                state_next = ST_IDLE;
                            else
                                state_next = ST_EMIT;
                        end
                        FC_WRITE_MANY:
                        begin
                            if (n_reg < 7'd9 || {8'd0, n_reg} < wm_need)
                                state_next = ST_IDLE;
                            else
                                state_next = ST_WM_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WM_RD:  state_next = ST_WM_CAP;
            ST_WM_CAP: state_next = ST_WM_BIT;
            ST_WM_BIT:
            begin
                if ({7'd0, i_reg} == qty)
                    state_next = ST_EMIT;
                else if (addr_sum >= 17'(COIL_COUNT))
                    state_next = ST_IDLE;
                else if (i_reg[2:0] == 3'd7)
                    state_next = ST_WM_RD;
            end
            ST_RC_RD:  state_next = ST_RC_CAP;
            ST_RC_CAP: state_next = (i_reg[2:0] == 3'd7) ? ST_EMIT : ST_RC_RD;
            ST_EMIT:
            begin
                if (!crc_byte)
                    state_next = ST_EM_BIT;
                else if (pos_reg == last_pos)
                    state_next = ST_IDLE;
                else if (kind_reg == RK_READ && pos_reg + 6'd1 >= 6'd3
                         && pos_reg + 6'd1 < nb_reg + 6'd3)
                    state_next = ST_RC_RD;
                else
                    state_next = ST_EMIT;
            end
            ST_EM_BIT:
            begin
                if (bit_reg == 3'd7)
                begin
                    if (pos_reg == last_pos)
                        state_next = ST_IDLE;
                    else if (kind_reg == RK_READ && pos_reg + 6'd1 >= 6'd3
                             && pos_reg + 6'd1 < nb_reg + 6'd3)
                        state_next = ST_RC_RD;
                    else
                        state_next = ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        n_next        = n_reg;
        kind_next     = kind_reg;
        crc_next      = crc_reg;
        bit_next      = bit_reg;
        idx_next      = idx_reg;
        i_next        = i_reg;
        pos_next      = pos_reg;
        nb_next       = nb_reg;
        code_next     = code_reg;
        data_next     = data_reg;
        tx_byte_next  = tx_byte_reg;
        tx_last_next  = tx_last_reg;
        tx_valid_next = 1'b0;
        coil_we       = 1'b0;
        coil_waddr    = hdr_reg[3];
        coil_wdata    = 1'b0;
        frame_raddr   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (frame_end)
                    begin
                        count_next = 7'd0;
                        n_next     = (count_reg < 7'(FRAME_BYTES)) ? count_reg + 7'd1
                                                                    : 7'(FRAME_BYTES + 1);
                        crc_next   = CRC_INIT;
                        idx_next   = 6'd0;
                    end
                    else
                        count_next = (count_reg < 7'(FRAME_BYTES)) ? count_reg + 7'd1
                                                                    : 7'(FRAME_BYTES + 1);
                end
            end
            ST_CK_XOR:
            begin
                crc_next = crc_reg ^ {8'd0, frame_rd_reg};
                bit_next = 3'd0;
            end
            ST_CK_BIT:
            begin
                crc_next = crc_step(crc_reg);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                    idx_next = idx_reg + 6'd1;
            end
            ST_CHECK:
            begin
                crc_next  = CRC_INIT;
                pos_next  = 6'd0;
                i_next    = 9'd0;
                kind_next = RK_ECHO;
                if (hdr_reg[1] == FC_READ)
                begin
                    if (n_reg != 7'd8)
                    begin
                        kind_next = RK_EXC;
                        code_next = ERR_OTHER;
                    end
                    else if (qty > {7'd0, len_max_reg} || qty > READ_COUNT_CAP)
                    begin
                        kind_next = RK_EXC;
                        code_next = ERR_DATA;
                    end
                    else
                    begin
                        kind_next = RK_READ;
                        nb_next   = rd_nb[8:3];
                    end
                end
                else if (hdr_reg[1] == FC_WRITE_ONE)
                begin
                    if (n_reg != 7'd8)
                    begin
                        kind_next = RK_EXC;
                        code_next = ERR_OTHER;
                    end
                    else if (crc_ok && addr < 16'(COIL_COUNT))
                    begin
                        coil_we    = 1'b1;
                        coil_wdata = (qty != 16'd0);
                    end
                end
            end
            ST_WM_RD:
                frame_raddr = FRAME_AW'(7) + i_reg[8:3];
            ST_WM_CAP:
                data_next = frame_rd_reg;
            ST_WM_BIT:
            begin
                if ({7'd0, i_reg} != qty && addr_sum < 17'(COIL_COUNT))
                begin
                    coil_we    = 1'b1;
                    coil_waddr = addr_sum[COIL_AW-1:0];
                    coil_wdata = data_reg[i_reg[2:0]];
                    i_next     = i_reg + 9'd1;
                end
            end
            ST_RC_CAP:
            begin
                data_next[i_reg[2:0]] = ({7'd0, i_reg} < qty) && coil_rd_reg;
                i_next = i_reg + 9'd1;
            end
            ST_EMIT:
            begin
                tx_valid_next = 1'b1;
                tx_byte_next  = src_byte;
                tx_last_next  = (pos_reg == last_pos);
                if (!crc_byte)
                begin
                    crc_next = crc_reg ^ {8'd0, src_byte};
                    bit_next = 3'd0;
                end
                else
                begin
                    pos_next  = pos_reg + 6'd1;
                    data_next = 8'd0;
                end
            end
            ST_EM_BIT:
            begin
                crc_next = crc_step(crc_reg);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    pos_next  = pos_reg + 6'd1;
                    data_next = 8'd0;
                end
            end
            default:
            begin
                crc_next = crc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kind_reg     <= RK_EXC;
            count_reg    <= 7'd0;
            n_reg        <= 7'd0;
            crc_reg      <= CRC_INIT;
            bit_reg      <= 3'd0;
            idx_reg      <= 6'd0;
            i_reg        <= 9'd0;
            pos_reg      <= 6'd0;
            nb_reg       <= 6'd0;
            tx_valid_reg <= 1'b0;
            addr_min_reg <= 8'd0;
            addr_max_reg <= 8'd255;
            len_max_reg  <= 9'd256;
            coil_vld_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            count_reg    <= count_next;
            n_reg        <= n_next;
            crc_reg      <= crc_next;
            bit_reg      <= bit_next;
            idx_reg      <= idx_next;
            i_reg        <= i_next;
            pos_reg      <= pos_next;
            nb_reg       <= nb_next;
            tx_valid_reg <= tx_valid_next;
            if (coil_we)
                coil_vld_reg[coil_waddr] <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ADDR_MIN: addr_min_reg <= cfg_data[7:0];
                    CFG_ADDR_MAX: addr_max_reg <= cfg_data[7:0];
                    CFG_LEN_MAX:  len_max_reg  <= cfg_data;
                    default:      len_max_reg  <= len_max_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        data_reg    <= data_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
        if (accept)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= rx_byte;
            if (count_reg < 7'd6)
                hdr_reg[count_reg[2:0]] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && count_reg < 7'(FRAME_BYTES))
            frame_mem[count_reg[FRAME_AW-1:0]] <= rx_byte;
        frame_rd_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coil_we)
            coil_mem[coil_waddr] <= coil_wdata;
        coil_rd_reg <= coil_mem[coil_raddr] & coil_vld_reg[coil_raddr];
    end

endmodule

@@ sv/mrcs_checker.sv @@
`timescale 1ns / 1ps

module mrcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       frame_end,
    input logic       tx_valid,
    input logic       tx_last,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // A byte that does not end a frame leaves the block idle.
    a_mid_byte_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !frame_end |=> !busy)
        else $error("busy after a mid-frame byte");

    // The final response byte is never followed directly by another byte.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_last |=> !tx_valid)
        else $error("strobe right after last response byte");

    // Response bytes only come out of frame processing.
    a_tx_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> $past(busy))
        else $error("strobe without preceding busy cycle");

    // Configuration is taken only while no frame is being processed.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !busy)
        else $error("configuration taken while busy");

endmodule

bind modbus_rtu_coil_server_unit mrcs_checker u_mrcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .frame_end (frame_end),
    .tx_valid  (tx_valid),
    .tx_last   (tx_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
